FILE: hdl/sis_pkg.sv
// shared constants, codes and types for the sparse integer set
`timescale 1ns / 1ps
package sis_pkg;

	localparam int UNIVERSE_SIZE = 1024;
	localparam int ADDR_W        = $clog2(UNIVERSE_SIZE);
	localparam int OP_W          = 2;
	localparam int VAL_W         = 10;
	localparam int CNT_W         = 11;

	typedef enum logic [OP_W-1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_QUERY  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_INIT,
		ST_IDLE,
		ST_CHECK,
		ST_DECIDE
	} state_t;

	// accesses from the sequencer to the two memories
	typedef struct packed {
		logic              sp_rd_en;
		logic [ADDR_W-1:0] sp_rd_addr;
		logic              sp_wr_en;
		logic [ADDR_W-1:0] sp_wr_addr;
		logic [CNT_W-1:0]  sp_wr_data;
		logic              dn_rd_en;
		logic [ADDR_W-1:0] dn_rd_addr_a;
		logic [ADDR_W-1:0] dn_rd_addr_b;
		logic              dn_wr_en;
		logic [ADDR_W-1:0] dn_wr_addr;
		logic [VAL_W-1:0]  dn_wr_data;
	} store_req_t;

	typedef struct packed {
		logic [CNT_W-1:0] sp_rd_data;
		logic [VAL_W-1:0] dn_rd_data_a;
		logic [VAL_W-1:0] dn_rd_data_b;
		logic             init_busy;
	} store_rsp_t;

endpackage

FILE: hdl/sis_in_if.sv
// command channel: operation and value
`timescale 1ns / 1ps
interface sis_in_if import sis_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  operation;
	logic [VAL_W-1:0] value;

	modport source (output valid, output operation, output value, input ready);
	modport sink (input valid, input operation, input value, output ready);
endinterface

FILE: hdl/sis_out_if.sv
// result channel: membership, count and range flag
`timescale 1ns / 1ps
interface sis_out_if import sis_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             was_present;
	logic [CNT_W-1:0] member_count;
	logic             out_of_range;

	modport source (output valid, output was_present, output member_count,
		output out_of_range, input ready);
	modport sink (input valid, input was_present, input member_count,
		input out_of_range, output ready);
endinterface

FILE: hdl/sparse_integer_set_core.sv
// sparse integer set: an accepted command passes through the CHECK and DECIDE states before its result is registered
// one command at a time: a new command is taken only after the index read, member read and
// write-back steps that share the two memory ports; a full result register stalls the write-back step
// clear passes through the same steps: membership also checks the member slot, so stale index entries are harmless
// after reset a sweep zeroes all 1024 sparse index entries; cmd.ready stays low until it ends
`timescale 1ns / 1ps
module sparse_integer_set_core import sis_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	sis_in_if.sink    cmd,
	sis_out_if.source rsp
);

	state_t            state_q;
	state_t            state_d;
	op_t               op_q;
	logic [VAL_W-1:0]  val_q;
	logic [CNT_W-1:0]  pos_q;
	logic              pos_ok_q;
	logic [CNT_W-1:0]  total_q;
	logic [CNT_W-1:0]  total_d;
	logic              out_v_q;
	logic              out_present_q;
	logic [CNT_W-1:0]  out_count_q;
	logic              out_oor_q;

	store_req_t        st_req;
	store_rsp_t        st_rsp;

	logic              out_free;
	logic              fire;
	logic              is_clear;
	logic              is_oor;
	logic              present;
	logic              do_add;
	logic              do_rem;
	logic [CNT_W-1:0]  pos_m1;
	logic [CNT_W-1:0]  pos_m1_q;
	logic [CNT_W-1:0]  last_idx;
	logic [CNT_W-1:0]  total_p1;

	sis_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (st_req),
		.rsp    (st_rsp)
	);

	assign out_free = !out_v_q || rsp.ready;
	assign fire     = (state_q == ST_DECIDE) && out_free;
	assign is_clear = (op_q == OP_CLEAR);
	assign is_oor   = !is_clear && ({1'b0, val_q} >= CNT_W'(UNIVERSE_SIZE));
	// a member's slot is within the count and the dense entry there names it
	assign present  = !is_clear && !is_oor && pos_ok_q && (st_rsp.dn_rd_data_a == val_q);
	assign do_add   = (op_q == OP_ADD) && !is_oor && !present
		&& (total_q < CNT_W'(UNIVERSE_SIZE));
	assign do_rem   = (op_q == OP_REMOVE) && present;
	assign pos_m1   = st_rsp.sp_rd_data - CNT_W'(1);
	assign pos_m1_q = pos_q - CNT_W'(1);
	assign last_idx = total_q - CNT_W'(1);
	assign total_p1 = total_q + CNT_W'(1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (!st_rsp.init_busy) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (cmd.valid) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

	// memory accesses and count update
	always_comb begin
		st_req              = '0;
		st_req.sp_rd_addr   = cmd.value[ADDR_W-1:0];
		st_req.dn_rd_addr_a = pos_m1[ADDR_W-1:0];
		st_req.dn_rd_addr_b = last_idx[ADDR_W-1:0];
		total_d             = total_q;
		case (state_q)
			ST_IDLE: begin
				st_req.sp_rd_en = cmd.valid;
			end
			ST_CHECK: begin
				st_req.dn_rd_en = 1'b1;
			end
			ST_DECIDE: begin
				if (fire) begin
					if (is_clear) begin
						total_d = '0;
					end else if (do_add) begin
						st_req.dn_wr_en   = 1'b1;
						st_req.dn_wr_addr = total_q[ADDR_W-1:0];
						st_req.dn_wr_data = val_q;
						st_req.sp_wr_en   = 1'b1;
						st_req.sp_wr_addr = val_q[ADDR_W-1:0];
						st_req.sp_wr_data = total_p1;
						total_d           = total_p1;
					end else if (do_rem) begin
						// last member moves into the freed slot
						st_req.dn_wr_en   = 1'b1;
						st_req.dn_wr_addr = pos_m1_q[ADDR_W-1:0];
						st_req.dn_wr_data = st_rsp.dn_rd_data_b;
						st_req.sp_wr_en   = 1'b1;
						st_req.sp_wr_addr = st_rsp.dn_rd_data_b[ADDR_W-1:0];
						st_req.sp_wr_data = pos_q;
						total_d           = last_idx;
					end
				end
			end
			default: begin
				st_req.sp_rd_en = 1'b0;
			end
		endcase
	end

	assign cmd.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			total_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			total_q <= total_d;
			if (fire) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			op_q  <= op_t'(cmd.operation);
			val_q <= cmd.value;
		end
		if (state_q == ST_CHECK) begin
			pos_q    <= st_rsp.sp_rd_data;
			pos_ok_q <= (st_rsp.sp_rd_data != '0) && (st_rsp.sp_rd_data <= total_q);
		end
		if (fire) begin
			out_present_q <= present;
			out_count_q   <= total_d;
			out_oor_q     <= is_oor;
		end
	end

	assign rsp.valid        = out_v_q;
	assign rsp.was_present  = out_present_q;
	assign rsp.member_count = out_count_q;
	assign rsp.out_of_range = out_oor_q;

	a_no_accept_during_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		st_rsp.init_busy |-> !cmd.ready)
		else $error("command accepted during index sweep");

	a_count_in_universe: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CNT_W'(UNIVERSE_SIZE))
		else $error("member count exceeds universe");

	a_accept_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready) |=> (state_q == ST_CHECK))
		else $error("accepted command did not start lookup");

	a_fire_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> (out_v_q && (out_count_q == total_q)))
		else $error("result count does not match member count");

endmodule

FILE: hdl/sis_store.sv
// sparse index and dense member memories with the post-reset index sweep
`timescale 1ns / 1ps
module sis_store import sis_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  store_req_t req,
	output store_rsp_t rsp
);

	logic [CNT_W-1:0]  sparse_mem [UNIVERSE_SIZE];
	logic [VAL_W-1:0]  dense_mem [UNIVERSE_SIZE];
	logic [CNT_W-1:0]  sp_rd_q;
	logic [VAL_W-1:0]  dn_rd_a_q;
	logic [VAL_W-1:0]  dn_rd_b_q;
	logic              init_busy_q;
	logic [ADDR_W-1:0] init_cnt_q;

	// one index entry zeroed per cycle after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_busy_q <= 1'b1;
			init_cnt_q  <= '0;
		end else if (init_busy_q) begin
			init_cnt_q <= init_cnt_q + ADDR_W'(1);
			if (init_cnt_q == ADDR_W'(UNIVERSE_SIZE - 1)) begin
				init_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (init_busy_q) begin
			sparse_mem[init_cnt_q] <= '0;
		end else if (req.sp_wr_en) begin
			sparse_mem[req.sp_wr_addr] <= req.sp_wr_data;
		end
		if (req.sp_rd_en) begin
			sp_rd_q <= sparse_mem[req.sp_rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (req.dn_wr_en) begin
			dense_mem[req.dn_wr_addr] <= req.dn_wr_data;
		end
		if (req.dn_rd_en) begin
			dn_rd_a_q <= dense_mem[req.dn_rd_addr_a];
			dn_rd_b_q <= dense_mem[req.dn_rd_addr_b];
		end
	end

	assign rsp.sp_rd_data   = sp_rd_q;
	assign rsp.dn_rd_data_a = dn_rd_a_q;
	assign rsp.dn_rd_data_b = dn_rd_b_q;
	assign rsp.init_busy    = init_busy_q;

endmodule
